[rtl/core/sha_pkg.sv]
// sha-256 package: round constants, initial hash values, operation codes, helper functions
// no dependencies
package sha_pkg;

  typedef enum logic [1:0] {
    OP_ABSORB  = 2'd0,
    OP_FINAL   = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef logic [31:0] word_t;

  function automatic word_t round_const(input logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0: k = 32'h428A2F98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hB5C0FBCF;
      6'd3: k = 32'hE9B5DBA5;  6'd4: k = 32'h3956C25B;  6'd5: k = 32'h59F111F1;
      6'd6: k = 32'h923F82A4;  6'd7: k = 32'hAB1C5ED5;  6'd8: k = 32'hD807AA98;
      6'd9: k = 32'h12835B01;  6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
      6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE; 6'd14: k = 32'h9BDC06A7;
      6'd15: k = 32'hC19BF174; 6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
      6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC; 6'd20: k = 32'h2DE92C6F;
      6'd21: k = 32'h4A7484AA; 6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
      6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D; 6'd26: k = 32'hB00327C8;
      6'd27: k = 32'hBF597FC7; 6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
      6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27B70A85;
      6'd33: k = 32'h2E1B2138; 6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
      6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB; 6'd38: k = 32'h81C2C92E;
      6'd39: k = 32'h92722C85; 6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
      6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3; 6'd44: k = 32'hD192E819;
      6'd45: k = 32'hD6990624; 6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
      6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08; 6'd50: k = 32'h2748774C;
      6'd51: k = 32'h34B0BCB5; 6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
      6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3; 6'd56: k = 32'h748F82EE;
      6'd57: k = 32'h78A5636F; 6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
      6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB; 6'd62: k = 32'hBEF9A3F7;
      default: k = 32'hC67178F2;
    endcase
    return k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t h;
    unique case (idx)
      3'd0: h = 32'h6A09E667; 3'd1: h = 32'hBB67AE85;
      3'd2: h = 32'h3C6EF372; 3'd3: h = 32'hA54FF53A;
      3'd4: h = 32'h510E527F; 3'd5: h = 32'h9B05688C;
      3'd6: h = 32'h1F83D9AB; default: h = 32'h5BE0CD19;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // compression engine control
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } eng_ctl_t;

endpackage

[rtl/core/sha_round_engine.sv]
// sha-256 compression engine: one round per cycle over a 16-word rolling schedule
// depends on sha_pkg; the chain words and block words come from the top level
module sha_round_engine (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  sha_pkg::word_t [15:0]  blk_words,
  input  sha_pkg::word_t [7:0]   chain_in,
  output sha_pkg::word_t [7:0]   chain_out,
  output sha_pkg::eng_ctl_t      ctl
);
  import sha_pkg::*;

  word_t [15:0] w_r, w_nxt;
  word_t [7:0]  v_r, v_nxt;
  logic  [5:0]  rnd_r;
  logic         busy_r, done_r;

  word_t s0, s1, sum0, sum1, ch, maj, t1, t2, wnew;

  always_comb begin
    s0   = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1   = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wnew = s1 + w_r[9] + s0 + w_r[0];
    sum1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    sum0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    maj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1   = v_r[7] + sum1 + ch + round_const(rnd_r) + w_r[0];
    t2   = sum0 + maj;
    v_nxt = {v_r[6], v_r[5], v_r[4], v_r[3] + t1, v_r[2], v_r[1], v_r[0], t1 + t2};
    w_nxt = {wnew, w_r[15:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      w_r <= blk_words;
      v_r <= chain_in;
    end else if (busy_r) begin
      w_r <= w_nxt;
      v_r <= v_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) chain_out[i] = chain_in[i] + v_r[i];
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = done_r;

endmodule

[rtl/core/sha256_byte_stream_hasher.sv]
// Byte-stream SHA-256 hasher. Each input transfer carries one operation: absorb a byte,
// finalize, or restart. The 64th byte of a block starts a compression (64 rounds in one
// shared round unit, plus load and update); any other absorb leaves in_tready high.
// Finalize runs one or two compressions and then presents the eight digest words, H0 first,
// one per output transfer, the last marked by out_tlast. in_tready is low meanwhile.
// top level; depends on sha_pkg and sha_round_engine
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [1:0] operation, [9:2] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // last_word
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_COMP, ST_WAIT, ST_PAD2, ST_EMIT
  } state_t;

  state_t        state_r;
  word_t [7:0]   chain_r;
  word_t [7:0]   chain_new;
  word_t         buf_r [16];    // block buffer, big-endian bytes within each word
  word_t         pad_words [16];
  word_t         absorb_word;
  logic [5:0]    fill_r;
  logic [63:0]   bits_r;
  logic          fin_r;
  logic          final_pend_r;  // finalize continues after this compression
  logic          second_r;      // length block still to go
  logic [2:0]    widx_r;
  logic          start_r;
  eng_ctl_t      ectl;
  word_t [15:0]  blk;

  logic [1:0] op;
  logic [7:0] dbyte;
  logic       acc;

  assign op    = in_tdata[1:0];
  assign dbyte = in_tdata[9:2];
  assign in_tready = (state_r == ST_IDLE);
  assign acc   = in_tvalid && in_tready;

  always_comb begin
    for (int i = 0; i < 16; i++)
      blk[i] = buf_r[i];
  end

  sha_round_engine u_eng (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_r),
    .blk_words (blk),
    .chain_in  (chain_r),
    .chain_out (chain_new),
    .ctl       (ectl)
  );

  // byte merge for absorb and the padded block for finalize
  always_comb begin
    absorb_word = buf_r[fill_r[5:2]];
    absorb_word[{~fill_r[1:0], 3'b000} +: 8] = dbyte;
    for (int w = 0; w < 16; w++) begin
      for (int b = 0; b < 4; b++) begin
        if (4*w + b == int'(fill_r))
          pad_words[w][8*(3-b) +: 8] = 8'h80;
        else if (4*w + b > int'(fill_r)) begin
          if (fill_r < 6'd56 && w >= 14)
            pad_words[w][8*(3-b) +: 8] = (w == 14) ? bits_r[32 + 8*(3-b) +: 8]
                                                   : bits_r[8*(3-b) +: 8];
          else
            pad_words[w][8*(3-b) +: 8] = 8'h00;
        end else
          pad_words[w][8*(3-b) +: 8] = buf_r[w][8*(3-b) +: 8];
      end
    end
  end

  // block buffer writes, including padding for finalize
  always_ff @(posedge clk) begin
    if (acc && op == OP_ABSORB && !fin_r) begin
      buf_r[fill_r[5:2]] <= absorb_word;
    end else if (acc && op == OP_FINAL && !fin_r) begin
      for (int w = 0; w < 16; w++) buf_r[w] <= pad_words[w];
    end else if (state_r == ST_PAD2) begin
      for (int w = 0; w < 14; w++) buf_r[w] <= '0;
      buf_r[14] <= bits_r[63:32];
      buf_r[15] <= bits_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      bits_r       <= '0;
      fin_r        <= 1'b0;
      final_pend_r <= 1'b0;
      second_r     <= 1'b0;
      widx_r       <= '0;
      start_r      <= 1'b0;
      for (int i = 0; i < 8; i++) chain_r[i] <= init_hash(3'(i));
    end else begin
      start_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (acc) begin
            if (op == OP_RESTART) begin
              for (int i = 0; i < 8; i++) chain_r[i] <= init_hash(3'(i));
              fill_r <= '0;
              bits_r <= '0;
              fin_r  <= 1'b0;
            end else if (op == OP_ABSORB && !fin_r) begin
              bits_r <= bits_r + 64'd8;
              fill_r <= fill_r + 6'd1;
              if (fill_r == 6'd63) begin
                final_pend_r <= 1'b0;
                start_r      <= 1'b1;
                state_r      <= ST_COMP;
              end
            end else if (op == OP_FINAL && !fin_r) begin
              final_pend_r <= 1'b1;
              second_r     <= (fill_r >= 6'd56);
              fill_r       <= '0;
              start_r      <= 1'b1;
              state_r      <= ST_COMP;
            end
          end
        end
        ST_COMP: state_r <= ST_WAIT;
        ST_WAIT: begin
          if (ectl.done) begin
            chain_r <= chain_new;
            if (!final_pend_r) state_r <= ST_IDLE;
            else if (second_r) begin
              second_r <= 1'b0;
              state_r  <= ST_PAD2;
            end else begin
              fin_r   <= 1'b1;
              widx_r  <= '0;
              state_r <= ST_EMIT;
            end
          end
        end
        ST_PAD2: begin
          start_r <= 1'b1;
          state_r <= ST_COMP;
        end
        ST_EMIT: begin
          if (out_tready) begin
            widx_r <= widx_r + 3'd1;
            if (widx_r == 3'd7) state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tdata  = chain_r[widx_r];
  assign out_tuser  = widx_r;
  assign out_tlast  = (widx_r == 3'd7);

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ectl.busy |-> !in_tready) else $error("input taken during compression");
  a_emit_only_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> fin_r) else $error("digest shown before finalize");
  a_last_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> !out_tvalid)
    else $error("digest continued past last word");
`endif

endmodule
